@@ rtl/core/ktpt_pkg.sv @@
// Shared types and constants for the keyed top price table.
package ktpt_pkg;

    localparam int KEY_W    = 16;
    localparam int DETAIL_W = 64;
    localparam int PRICE_W  = 31;
    localparam int LIMIT_W  = 7;
    localparam int USED_W   = 7;
    // Wide enough to address the largest supported table.
    localparam int SLOT_W   = 6;

    localparam logic [PRICE_W-1:0] MAX_INT = {PRICE_W{1'b1}};

    localparam logic CMD_SALE = 1'b0;
    localparam logic CMD_LIST = 1'b1;

    typedef struct packed {
        logic                cmd;
        logic                item_known;
        logic                net_valued;
        logic [KEY_W-1:0]    item_key;
        logic [DETAIL_W-1:0] item_detail;
        logic [PRICE_W-1:0]  sale_price;
        logic [LIMIT_W-1:0]  list_limit;
    } req_word_t;

    typedef struct packed {
        logic                entry_valid;
        logic [KEY_W-1:0]    entry_key;
        logic [DETAIL_W-1:0] entry_detail;
        logic [PRICE_W-1:0]  entry_price;
        logic                table_changed;
        logic                dirty_flag;
        logic [USED_W-1:0]   entries_used;
        logic                last_in_run;
    } rsp_word_t;

    // Item under work, seen by every cell at once.
    typedef struct packed {
        logic                net;
        logic [KEY_W-1:0]    key;
        logic [DETAIL_W-1:0] detail;
        logic [PRICE_W-1:0]  price;
    } bcast_t;

    // Search state handed from one cell to the next.
    typedef struct packed {
        logic               act;
        logic               matched;
        logic               raise;
        logic [SLOT_W-1:0]  idx;
        logic               min_found;
        logic [PRICE_W-1:0] min_price;
        logic [SLOT_W-1:0]  min_idx;
    } token_t;

    typedef struct packed {
        logic              en;
        logic              full;
        logic [SLOT_W-1:0] idx;
    } wr_ctl_t;

endpackage

@@ rtl/core/ktpt_cell.sv @@
// One table entry with its stage of the key match and minimum price search.
module ktpt_cell
    import ktpt_pkg::*;
#(
    parameter int CELL = 0
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                occ,
    input  bcast_t              bc,
    input  wr_ctl_t             wr,
    input  token_t              tok_in,
    output token_t              tok_out,
    output logic [KEY_W-1:0]    key,
    output logic [DETAIL_W-1:0] detail,
    output logic [PRICE_W-1:0]  price
);

    logic [KEY_W-1:0]    key_reg;
    logic [DETAIL_W-1:0] detail_reg;
    logic [PRICE_W-1:0]  price_reg;
    token_t              tok_reg;
    token_t              tok_next;
    logic                hit;
    logic                lower;
    logic                wr_here;

    assign wr_here = wr.en && (wr.idx == SLOT_W'(CELL));

    // Only the first matching key counts; later duplicates are passed over.
    assign hit   = occ && !bc.net && !tok_in.matched && (key_reg == bc.key);
    assign lower = occ && (price_reg < tok_in.min_price);

    always_comb
    begin
        tok_next           = tok_in;
        tok_next.matched   = tok_in.matched || hit;
        tok_next.raise     = hit ? (price_reg < bc.price) : tok_in.raise;
        tok_next.idx       = hit ? SLOT_W'(CELL) : tok_in.idx;
        tok_next.min_found = tok_in.min_found || lower;
        tok_next.min_price = lower ? price_reg : tok_in.min_price;
        tok_next.min_idx   = lower ? SLOT_W'(CELL) : tok_in.min_idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_here)
        begin
            price_reg <= bc.price;
            if (wr.full)
            begin
                key_reg    <= bc.key;
                detail_reg <= bc.detail;
            end
        end
    end

    assign tok_out = tok_reg;
    assign key     = key_reg;
    assign detail  = detail_reg;
    assign price   = price_reg;

endmodule

@@ rtl/core/keyed_top_price_table.sv @@
// Keyed top price table: top level with control, list streaming and result register.
//
// Holds up to ENTRIES (key, detail, price) entries in a row of cells. A sale of a
// known item sends a search word down the cell row, one cell per cycle, which finds
// the first key match (none for a net-valued item) and the lowest price below
// MAX_INT; the table is updated when the word leaves the last cell. A listing
// returns one entry per cycle while the result register is free; an unknown item
// or an empty listing skips the search. The block takes one item at a time; the
// result register lets it take the next item while the last result still waits.
// No clearing pass is needed after reset.
module keyed_top_price_table
    import ktpt_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_word_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESULT,
        S_LIST
    } state_t;

    state_t              state_reg;
    req_word_t           item_reg;
    logic                start_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                dirty_reg;
    logic                changed_reg;
    logic [IDX_W-1:0]    list_idx_reg;
    logic [CNT_W-1:0]    list_n_reg;
    logic                rsp_valid_reg;
    rsp_word_t           rsp_reg;

    bcast_t              bc;
    wr_ctl_t             wr;
    token_t              tok [ENTRIES+1];
    logic [ENTRIES-1:0]  act_vec;
    logic [KEY_W-1:0]    ent_key    [ENTRIES];
    logic [DETAIL_W-1:0] ent_detail [ENTRIES];
    logic [PRICE_W-1:0]  ent_price  [ENTRIES];

    logic                out_free;
    logic                rsp_load;
    logic                scan_done;
    logic                commit_changed;
    logic                commit_append;
    logic [USED_W-1:0]   cnt_ext;
    logic [LIMIT_W-1:0]  list_n_ext;
    logic                list_last;

    assign bc.net    = item_reg.net_valued;
    assign bc.key    = item_reg.item_key;
    assign bc.detail = item_reg.item_detail;
    assign bc.price  = item_reg.sale_price;

    always_comb
    begin
        tok[0]           = '0;
        tok[0].act       = start_reg;
        tok[0].min_price = MAX_INT;
    end

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        ktpt_cell #(
            .CELL (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .occ     (CNT_W'(i) < count_reg),
            .bc      (bc),
            .wr      (wr),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1]),
            .key     (ent_key[i]),
            .detail  (ent_detail[i]),
            .price   (ent_price[i])
        );
        assign act_vec[i] = tok[i+1].act;
    end

    assign scan_done = (state_reg == S_SCAN) && tok[ENTRIES].act;

    // Decide the single table write once the search word leaves the row.
    always_comb
    begin
        wr             = '0;
        commit_changed = 1'b0;
        commit_append  = 1'b0;
        if (scan_done)
        begin
            priority if (tok[ENTRIES].matched)
            begin
                if (tok[ENTRIES].raise)
                begin
                    wr.en          = 1'b1;
                    wr.idx         = tok[ENTRIES].idx;
                    commit_changed = 1'b1;
                end
            end
            else if (count_reg < CNT_W'(ENTRIES))
            begin
                wr.en          = 1'b1;
                wr.full        = 1'b1;
                wr.idx         = SLOT_W'(count_reg);
                commit_changed = 1'b1;
                commit_append  = 1'b1;
            end
            else if (tok[ENTRIES].min_found)
            begin
                wr.en          = 1'b1;
                wr.full        = 1'b1;
                wr.idx         = tok[ENTRIES].min_idx;
                commit_changed = 1'b1;
            end
        end
    end

    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign rsp_load   = out_free && ((state_reg == S_RESULT) || (state_reg == S_LIST));
    assign cnt_ext    = USED_W'(count_reg);
    assign list_n_ext = (LIMIT_W'(cnt_ext) < req.list_limit) ? LIMIT_W'(cnt_ext)
                                                              : req.list_limit;
    assign list_last  = (CNT_W'(list_idx_reg) + CNT_W'(1)) == list_n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_reg      <= '0;
            start_reg     <= 1'b0;
            count_reg     <= '0;
            dirty_reg     <= 1'b0;
            changed_reg   <= 1'b0;
            list_idx_reg  <= '0;
            list_n_reg    <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            start_reg     <= (state_reg == S_IDLE) && req_valid && (req.cmd != CMD_LIST)
                             && req.item_known;
            rsp_valid_reg <= rsp_load || (rsp_valid_reg && rsp_stall);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        item_reg    <= req;
                        changed_reg <= 1'b0;
                        priority if (req.cmd == CMD_LIST)
                        begin
                            if (list_n_ext == '0)
                            begin
                                state_reg <= S_RESULT;
                            end
                            else
                            begin
                                list_n_reg   <= CNT_W'(list_n_ext);
                                list_idx_reg <= '0;
                                state_reg    <= S_LIST;
                            end
                        end
                        else if (req.item_known)
                        begin
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            state_reg <= S_RESULT;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (scan_done)
                    begin
                        changed_reg <= commit_changed;
                        if (commit_changed)
                        begin
                            dirty_reg <= 1'b1;
                        end
                        if (commit_append)
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        state_reg <= S_RESULT;
                    end
                end
                S_RESULT:
                begin
                    if (out_free)
                    begin
                        rsp_reg.entry_valid   <= 1'b0;
                        rsp_reg.entry_key     <= '0;
                        rsp_reg.entry_detail  <= '0;
                        rsp_reg.entry_price   <= '0;
                        rsp_reg.table_changed <= changed_reg;
                        rsp_reg.dirty_flag    <= dirty_reg;
                        rsp_reg.entries_used  <= cnt_ext;
                        rsp_reg.last_in_run   <= 1'b1;
                        state_reg             <= S_IDLE;
                    end
                end
                S_LIST:
                begin
                    if (out_free)
                    begin
                        rsp_reg.entry_valid   <= 1'b1;
                        rsp_reg.entry_key     <= ent_key[list_idx_reg];
                        rsp_reg.entry_detail  <= ent_detail[list_idx_reg];
                        rsp_reg.entry_price   <= ent_price[list_idx_reg];
                        rsp_reg.table_changed <= 1'b0;
                        rsp_reg.dirty_flag    <= dirty_reg;
                        rsp_reg.entries_used  <= cnt_ext;
                        rsp_reg.last_in_run   <= list_last;
                        list_idx_reg          <= list_idx_reg + IDX_W'(1);
                        if (list_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // At most one search word is ever in the cell row.
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(act_vec))
        else $error("more than one search word in the cell row");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("entry count exceeds table size");

    a_dirty_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(dirty_reg))
        else $error("dirty mark cleared without reset");

    a_write_on_scan: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (state_reg == S_SCAN) && commit_changed)
        else $error("table write outside the end of a search");

    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> (state_reg == S_SCAN) && $past(state_reg == S_IDLE))
        else $error("search word launched outside a sale");

endmodule

@@ bench/tb_keyed_top_price_table.sv @@
// Self-checking testbench for the keyed top price table with a built-in table predictor.
module tb_keyed_top_price_table
    import ktpt_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH  = 16;
    localparam int RANDOM_WORDS = 41;
    localparam int SETTLE_CYCLES = 3 * TABLE_DEPTH + 10;

    typedef struct {
        req_word_t w;
        bit        typed;
        rsp_word_t want;
    } stim_row_t;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_word_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_word_t rsp;

    // Copy of the price table as the block should hold it.
    logic [KEY_W-1:0]    book_keys    [TABLE_DEPTH];
    logic [DETAIL_W-1:0] book_details [TABLE_DEPTH];
    logic [PRICE_W-1:0]  book_prices  [TABLE_DEPTH];
    int                  book_used;
    bit                  book_dirty;

    rsp_word_t expected_rsp[$];

    // Typed expectation that travels with the word currently on the request side.
    bit        row_typed;
    rsp_word_t row_want;

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int results_checked;
    int words_sent;
    int sales_seen;
    int sales_changed;
    int lists_seen;

    keyed_top_price_table #(
        .ENTRIES(TABLE_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic req_word_t sale_word(input bit known, input bit net,
                                            input logic [KEY_W-1:0] key,
                                            input logic [DETAIL_W-1:0] detail,
                                            input logic [PRICE_W-1:0] price);
        req_word_t w;
        w = '0;
        w.cmd = CMD_SALE;
        w.item_known = known;
        w.net_valued = net;
        w.item_key = key;
        w.item_detail = detail;
        w.sale_price = price;
        return w;
    endfunction

    function automatic req_word_t list_word(input logic [LIMIT_W-1:0] limit);
        req_word_t w;
        w = '0;
        w.cmd = CMD_LIST;
        w.list_limit = limit;
        return w;
    endfunction

    // Result of a sale or of an empty listing: no entry, a single word.
    function automatic rsp_word_t plain_result(input bit changed, input bit dirty,
                                               input int used);
        rsp_word_t r;
        r = '0;
        r.table_changed = changed;
        r.dirty_flag = dirty;
        r.entries_used = USED_W'(used);
        r.last_in_run = 1'b1;
        return r;
    endfunction

    // Applies one known sale to the table copy and tells whether it changed anything.
    function automatic bit apply_sale(input req_word_t w);
        int match_idx;
        int low_idx;
        logic [PRICE_W-1:0] low_price;
        match_idx = -1;
        low_idx = -1;
        low_price = MAX_INT;
        if (!w.net_valued)
        begin
            for (int i = 0; i < book_used; i++)
                if (match_idx < 0 && book_keys[i] == w.item_key)
                    match_idx = i;
        end
        if (match_idx >= 0)
        begin
            if (book_prices[match_idx] < w.sale_price)
            begin
                book_prices[match_idx] = w.sale_price;
                return 1'b1;
            end
            return 1'b0;
        end
        if (book_used < TABLE_DEPTH)
        begin
            book_keys[book_used] = w.item_key;
            book_details[book_used] = w.item_detail;
            book_prices[book_used] = w.sale_price;
            book_used++;
            return 1'b1;
        end
        // Full table: the first entry with the lowest price below the ceiling is replaced.
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (book_prices[i] < low_price)
            begin
                low_price = book_prices[i];
                low_idx = i;
            end
        if (low_idx < 0)
            return 1'b0;
        book_keys[low_idx] = w.item_key;
        book_details[low_idx] = w.item_detail;
        book_prices[low_idx] = w.sale_price;
        return 1'b1;
    endfunction

    task automatic predict_word(input req_word_t w);
        rsp_word_t r;
        rsp_word_t words[$];
        bit changed;
        int n;
        if (w.cmd == CMD_LIST)
        begin
            lists_seen++;
            n = (book_used < int'(w.list_limit)) ? book_used : int'(w.list_limit);
            if (n == 0)
                words.push_back(plain_result(1'b0, book_dirty, book_used));
            for (int i = 0; i < n; i++)
            begin
                r = plain_result(1'b0, book_dirty, book_used);
                r.entry_valid = 1'b1;
                r.entry_key = book_keys[i];
                r.entry_detail = book_details[i];
                r.entry_price = book_prices[i];
                r.last_in_run = (i == n - 1);
                words.push_back(r);
            end
        end
        else
        begin
            sales_seen++;
            changed = w.item_known ? apply_sale(w) : 1'b0;
            if (changed)
            begin
                book_dirty = 1'b1;
                sales_changed++;
            end
            words.push_back(plain_result(changed, book_dirty, book_used));
        end
        if (row_typed)
            expected_rsp.push_back(row_want);
        else
            foreach (words[i])
                expected_rsp.push_back(words[i]);
    endtask

    task automatic check_word(input rsp_word_t got, input rsp_word_t want);
        if (got.entry_valid !== want.entry_valid)
            report_mismatch("entry_valid", 64'(got.entry_valid), 64'(want.entry_valid));
        if (got.entry_key !== want.entry_key)
            report_mismatch("entry_key", 64'(got.entry_key), 64'(want.entry_key));
        if (got.entry_detail !== want.entry_detail)
            report_mismatch("entry_detail", got.entry_detail, want.entry_detail);
        if (got.entry_price !== want.entry_price)
            report_mismatch("entry_price", 64'(got.entry_price), 64'(want.entry_price));
        if (got.table_changed !== want.table_changed)
            report_mismatch("table_changed", 64'(got.table_changed),
                            64'(want.table_changed));
        if (got.dirty_flag !== want.dirty_flag)
            report_mismatch("dirty_flag", 64'(got.dirty_flag), 64'(want.dirty_flag));
        if (got.entries_used !== want.entries_used)
            report_mismatch("entries_used", 64'(got.entries_used), 64'(want.entries_used));
        if (got.last_in_run !== want.last_in_run)
            report_mismatch("last_in_run", 64'(got.last_in_run), 64'(want.last_in_run));
    endtask

    // Requests are predicted as they are accepted; results are checked as they are taken.
    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall)
            predict_word(req);
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp.size() == 0)
                report_mismatch("result word with nothing expected", rsp.entry_detail,
                                64'h0);
            else
                check_word(rsp, expected_rsp.pop_front());
            results_checked++;
        end
    end

    always @(negedge clk)
        rsp_stall = ($urandom_range(99) < recv_idle_pct);

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(input req_word_t w, input bit typed, input rsp_word_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req = w;
        row_typed = typed;
        row_want = want;
        req_valid = 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    // Mostly sales on keys already stored, so matches, raises and replacements are common.
    function automatic req_word_t random_word();
        req_word_t w;
        int kind;
        w.cmd = CMD_SALE;
        w.item_known = ($urandom_range(99) < 92);
        w.net_valued = ($urandom_range(99) < 25);
        w.item_key = KEY_W'($urandom);
        w.item_detail = {$urandom, $urandom};
        w.sale_price = PRICE_W'($urandom);
        w.list_limit = LIMIT_W'($urandom);
        if ($urandom_range(99) < 18)
        begin
            w.cmd = CMD_LIST;
            if ($urandom_range(99) < 70)
                w.list_limit = LIMIT_W'($urandom_range(0, TABLE_DEPTH + 1));
            return w;
        end
        kind = $urandom_range(99);
        if (book_used > 0 && kind < 55)
            w.item_key = book_keys[$urandom_range(0, book_used - 1)];
        else if (kind < 80)
            w.item_key = KEY_W'($urandom_range(0, 23));
        kind = $urandom_range(0, 19);
        if (kind == 0)
            w.sale_price = MAX_INT;
        else if (kind < 8)
            w.sale_price = PRICE_W'($urandom_range(0, 7));
        else if (kind >= 14)
            w.sale_price = PRICE_W'($urandom_range(0, 5000));
        return w;
    endfunction

    initial
    begin
        stim_row_t directed_rows[$];
        stim_row_t row;
        req_word_t w;
        int phase_send [3];
        int phase_recv [3];
        phase_send = '{14, 57, 0};
        phase_recv = '{57, 14, 0};

        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_stall = 1'b0;
        row_typed = 1'b0;
        row_want = '0;
        book_used = 0;
        book_dirty = 1'b0;
        send_idle_pct = phase_send[0];
        recv_idle_pct = phase_recv[0];
        mismatches = 0;
        results_checked = 0;
        words_sent = 0;
        sales_seen = 0;
        sales_changed = 0;
        lists_seen = 0;

        directed_rows.push_back('{list_word(64), 1'b1, plain_result(1'b0, 1'b0, 0)});
        directed_rows.push_back('{list_word(127), 1'b1, plain_result(1'b0, 1'b0, 0)});
        directed_rows.push_back('{sale_word(1'b0, 1'b0, '1, '1, MAX_INT), 1'b1,
                                  plain_result(1'b0, 1'b0, 0)});
        directed_rows.push_back('{sale_word(1'b1, 1'b0, '0, '0, '0), 1'b1,
                                  plain_result(1'b1, 1'b1, 1)});
        directed_rows.push_back('{list_word(0), 1'b1, plain_result(1'b0, 1'b1, 1)});
        // Raise, then an equal price and a lower price on the same key.
        directed_rows.push_back('{sale_word(1'b1, 1'b0, '0, 64'h1111, 5), 1'b0, '0});
        directed_rows.push_back('{sale_word(1'b1, 1'b0, '0, 64'h2222, 5), 1'b0, '0});
        directed_rows.push_back('{sale_word(1'b1, 1'b0, '0, 64'h3333, 4), 1'b0, '0});
        directed_rows.push_back('{sale_word(1'b1, 1'b0, '1, '1, MAX_INT), 1'b0, '0});
        // A net-valued sale stores a second entry with an existing key.
        directed_rows.push_back('{sale_word(1'b1, 1'b1, '0, 64'h4444, 3), 1'b0, '0});
        directed_rows.push_back('{sale_word(1'b0, 1'b1, 16'h0001, 64'h5555, 9), 1'b0, '0});
        directed_rows.push_back('{list_word(1), 1'b0, '0});
        directed_rows.push_back('{list_word(64), 1'b0, '0});
        directed_rows.push_back('{list_word(127), 1'b0, '0});
        directed_rows.push_back('{sale_word(1'b1, 1'b0, '1, '0, MAX_INT), 1'b0, '0});
        directed_rows.push_back('{list_word(3), 1'b0, '0});

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_word(row.w, row.typed, row.want);
        end

        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct = phase_send[p];
            recv_idle_pct = phase_recv[p];
            for (int k = 0; k < RANDOM_WORDS; k++)
                send_word(random_word(), 1'b0, '0);
        end

        // Push every price to the ceiling; after that no sale can change the full table.
        for (int k = 0; k < TABLE_DEPTH + 1; k++)
        begin
            w = random_word();
            w.cmd = CMD_SALE;
            w.item_known = 1'b1;
            w.net_valued = 1'b1;
            w.sale_price = MAX_INT;
            send_word(w, 1'b0, '0);
        end
        w = random_word();
        w.cmd = CMD_SALE;
        w.item_known = 1'b1;
        w.net_valued = 1'b0;
        send_word(w, 1'b0, '0);
        send_word(sale_word(1'b1, 1'b0, book_keys[0], '1, MAX_INT), 1'b0, '0);
        send_word(list_word(LIMIT_W'(TABLE_DEPTH)), 1'b0, '0);
        req_valid = 1'b0;

        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d request words: %0d sales (%0d changed the table), %0d listings.",
                 words_sent, sales_seen, sales_changed, lists_seen);
        $display("Checked %0d result words; %0d field mismatches.", results_checked, mismatches);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timed out with %0d result words outstanding.", expected_rsp.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
